[hdl/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg
// Shared widths, constants, register indexes and state codes for the
// potentiometer smoothing and calibration channel.
// ----------------------------------------------------------------------------
package psc_pkg;

    // Full scale of the converter and of the normalized output.
    localparam int RAW_MAX  = 4095;
    localparam int NORM_MAX = 1000;

    // Field widths.
    localparam int RAW_W  = 12;
    localparam int NORM_W = 10;
    localparam int DB_W   = 10;

    // Scaling dividend: offset * NORM_MAX + span / 2.
    localparam int PROD_W = $clog2(RAW_MAX * NORM_MAX + RAW_MAX / 2 + 1);
    // Quotient never exceeds NORM_MAX, so one spare bit covers it.
    localparam int QUO_W  = $clog2(NORM_MAX + 1) + 1;
    localparam int CNT_W  = $clog2(QUO_W);

    // Smoothing divisor is 8, a right shift by three.
    localparam int SMOOTH_SHIFT = 3;

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_RAW_MIN  = 2'd0;
    localparam reg_idx_t REG_RAW_MAX  = 2'd1;
    localparam reg_idx_t REG_INVERT   = 2'd2;
    localparam reg_idx_t REG_DEADBAND = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT,
        ST_MULT,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

[hdl/pot_smooth_calibrate.sv]
// ----------------------------------------------------------------------------
// pot_smooth_calibrate
// One potentiometer channel: exponential smoothing, calibration, scaling,
// optional inversion and a deadband on the held output.
// ----------------------------------------------------------------------------
// Usage:
// Raw converter readings enter on the s_ channel (s_valid, s_ready,
// s_raw_sample), one item per reading. Each accepted item yields exactly one
// result item on the m_ channel: the held normalized level, the filtered raw
// level and a calibration error flag.
// The first reading after reset or after any register write loads the filter
// directly; later readings move it by one eighth of the difference, at least
// one count. The filtered level is clamped to [raw_min, raw_max] and scaled
// with rounding to 0..NORM_MAX by a restoring divider that produces one
// quotient bit per cycle.
// Processing: an item is accepted in the idle state, then passes through the
// filter, the scaling multiply, the divider and the finish step; the result
// is registered, and the next item is taken only after the finish step has
// returned to idle. With a bad calibration (raw_max not above raw_min) the
// divider is skipped.
// The result sits in an output register; if the receiver stalls, the finish
// step waits until that register is free, and no new item is accepted
// meanwhile. Reset restores the register defaults and clears the filter,
// the held output and the primed flag; a register write clears the same
// state. The APB port has pready tied high and registers at 4*index.
// ----------------------------------------------------------------------------
module pot_smooth_calibrate (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psc_pkg::ADDR_W-1:0]    paddr,
    input  logic [psc_pkg::DATA_W-1:0]    pwdata,
    output logic [psc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // Sample input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [psc_pkg::RAW_W-1:0]     s_raw_sample,
    // Result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [psc_pkg::NORM_W-1:0]    m_level_out,
    output logic [psc_pkg::RAW_W-1:0]     m_smoothed_raw,
    output logic                          m_config_error
);
    import psc_pkg::*;

    // Configuration registers.
    logic [RAW_W-1:0]  raw_min_reg;
    logic [RAW_W-1:0]  raw_max_reg;
    logic              invert_reg;
    logic [DB_W-1:0]   deadband_reg;

    // Channel state.
    state_t            state_reg, state_next;
    logic [RAW_W-1:0]  sample_reg, sample_next;
    logic [RAW_W-1:0]  filt_reg, filt_next;
    logic [NORM_W-1:0] held_reg, held_next;
    logic              primed_reg, primed_next;
    logic              first_reg, first_next;
    logic              bad_reg, bad_next;

    // Divider datapath.
    logic [RAW_W-1:0]  span_reg, span_next;
    logic [RAW_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  shift_reg, shift_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [NORM_W-1:0] m_level_out_reg, m_level_out_next;
    logic [RAW_W-1:0]  m_smoothed_raw_reg, m_smoothed_raw_next;
    logic              m_config_error_reg, m_config_error_next;

    // Combinational helpers.
    logic              cfg_wr;
    logic [RAW_W-1:0]  hi_cal;
    logic [RAW_W-1:0]  raw_sat;
    logic [RAW_W-1:0]  diff;
    logic [RAW_W-1:0]  step;
    logic [RAW_W-1:0]  clamped;
    logic [PROD_W-1:0] dividend;
    logic [RAW_W:0]    trial;
    logic              trial_ge;
    logic [NORM_W-1:0] scaled;
    logic [NORM_W-1:0] cand;
    logic [NORM_W-1:0] change;
    logic              out_free;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign s_ready = (state_reg == ST_IDLE);

    assign m_valid        = m_valid_reg;
    assign m_level_out    = m_level_out_reg;
    assign m_smoothed_raw = m_smoothed_raw_reg;
    assign m_config_error = m_config_error_reg;

    // Register readback.
    always_comb begin
        prdata = '0;
        unique case (reg_idx_t'(paddr[3:2]))
            REG_RAW_MIN:  prdata = DATA_W'(raw_min_reg);
            REG_RAW_MAX:  prdata = DATA_W'(raw_max_reg);
            REG_INVERT:   prdata = DATA_W'(invert_reg);
            REG_DEADBAND: prdata = DATA_W'(deadband_reg);
            default:      prdata = '0;
        endcase
    end

    // Calibrated top of range, limited to converter full scale.
    assign hi_cal  = (32'(raw_max_reg) > RAW_MAX) ? RAW_W'(RAW_MAX) : raw_max_reg;
    assign raw_sat = (32'(sample_reg) > RAW_MAX) ? RAW_W'(RAW_MAX) : sample_reg;

    // Smoothing step: magnitude of the difference over eight, at least one.
    always_comb begin
        diff = (raw_sat > filt_reg) ? (raw_sat - filt_reg) : (filt_reg - raw_sat);
        step = diff >> SMOOTH_SHIFT;
        if (step == '0) begin
            step = RAW_W'(1);
        end
    end

    // Clamp into the calibrated range and form the rounding dividend.
    always_comb begin
        if (filt_reg < raw_min_reg) begin
            clamped = raw_min_reg;
        end else if (filt_reg > hi_cal) begin
            clamped = hi_cal;
        end else begin
            clamped = filt_reg;
        end
        dividend = PROD_W'(clamped - raw_min_reg) * PROD_W'(NORM_MAX)
                 + PROD_W'((hi_cal - raw_min_reg) >> 1);
    end

    // One restoring division step per cycle.
    assign trial    = {rem_reg, shift_reg[QUO_W-1]};
    assign trial_ge = (trial >= {1'b0, span_reg});

    // Finish step: inversion and deadband against the held value.
    always_comb begin
        scaled = quo_reg[NORM_W-1:0];
        cand   = invert_reg ? (NORM_W'(NORM_MAX) - scaled) : scaled;
        change = (cand > held_reg) ? (cand - held_reg) : (held_reg - cand);
    end

    assign out_free = !m_valid_reg || m_ready;

    // Next state and datapath control.
    always_comb begin
        state_next          = state_reg;
        sample_next         = sample_reg;
        filt_next           = filt_reg;
        held_next           = held_reg;
        primed_next         = primed_reg;
        first_next          = first_reg;
        bad_next            = bad_reg;
        span_next           = span_reg;
        rem_next            = rem_reg;
        shift_next          = shift_reg;
        quo_next            = quo_reg;
        cnt_next            = cnt_reg;
        m_valid_next        = m_valid_reg;
        m_level_out_next    = m_level_out_reg;
        m_smoothed_raw_next = m_smoothed_raw_reg;
        m_config_error_next = m_config_error_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sample_next = s_raw_sample;
                    state_next  = ST_FILT;
                end
            end
            ST_FILT: begin
                first_next  = !primed_reg;
                primed_next = 1'b1;
                if (!primed_reg) begin
                    filt_next = raw_sat;
                end else if (raw_sat > filt_reg) begin
                    filt_next = filt_reg + step;
                end else if (raw_sat < filt_reg) begin
                    filt_next = filt_reg - step;
                end
                bad_next   = (hi_cal <= raw_min_reg);
                state_next = ST_MULT;
            end
            ST_MULT: begin
                span_next  = hi_cal - raw_min_reg;
                rem_next   = RAW_W'(dividend[PROD_W-1:QUO_W]);
                shift_next = dividend[QUO_W-1:0];
                quo_next   = '0;
                cnt_next   = '0;
                state_next = bad_reg ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                rem_next   = trial_ge ? RAW_W'(trial - {1'b0, span_reg}) : RAW_W'(trial);
                shift_next = {shift_reg[QUO_W-2:0], 1'b0};
                quo_next   = {quo_reg[QUO_W-2:0], trial_ge};
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if (bad_reg) begin
                        held_next = '0;
                    end else if (first_reg || (change >= deadband_reg)) begin
                        held_next = cand;
                    end
                    m_valid_next        = 1'b1;
                    m_level_out_next    = bad_reg ? '0 :
                                          ((first_reg || (change >= deadband_reg)) ?
                                           cand : held_reg);
                    m_smoothed_raw_next = filt_reg;
                    m_config_error_next = bad_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Register write clears state; user must write in idle, not enforced.
        if (cfg_wr) begin
            filt_next   = '0;
            held_next   = '0;
            primed_next = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            filt_reg     <= '0;
            held_reg     <= '0;
            primed_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            raw_min_reg  <= '0;
            raw_max_reg  <= RAW_W'(RAW_MAX);
            invert_reg   <= 1'b0;
            deadband_reg <= '0;
        end else begin
            state_reg   <= state_next;
            filt_reg    <= filt_next;
            held_reg    <= held_next;
            primed_reg  <= primed_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr) begin
                unique case (reg_idx_t'(paddr[3:2]))
                    REG_RAW_MIN:  raw_min_reg  <= pwdata[RAW_W-1:0];
                    REG_RAW_MAX:  raw_max_reg  <= pwdata[RAW_W-1:0];
                    REG_INVERT:   invert_reg   <= pwdata[0];
                    REG_DEADBAND: deadband_reg <= pwdata[DB_W-1:0];
                    default:      raw_min_reg  <= raw_min_reg;
                endcase
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        sample_reg         <= sample_next;
        first_reg          <= first_next;
        bad_reg            <= bad_next;
        span_reg           <= span_next;
        rem_reg            <= rem_next;
        shift_reg          <= shift_next;
        quo_reg            <= quo_next;
        cnt_reg            <= cnt_next;
        m_level_out_reg    <= m_level_out_next;
        m_smoothed_raw_reg <= m_smoothed_raw_next;
        m_config_error_reg <= m_config_error_next;
    end

    // A calibration error always reports a zero level.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_config_error |-> m_level_out == '0)
        else $error("level_out not zero with config_error set");

    // A good calibration never scales past full scale.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_config_error |-> 32'(m_level_out) <= NORM_MAX)
        else $error("level_out above NORM_MAX");

    // The partial remainder stays below the divisor throughout the division.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> rem_reg < span_reg)
        else $error("divider remainder not below span");

    // Only one item is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in work");

endmodule
